// ----- rtl/cts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package cts_pkg;

    // default slot count
    localparam int DEF_SLOTS = 8;

    // request codes
    typedef enum logic [2:0] {
        REQ_SPAWN = 3'd0,
        REQ_YIELD = 3'd1,
        REQ_SCHED = 3'd2,
        REQ_EXIT  = 3'd3,
        REQ_GET   = 3'd4
    } t_req;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_RANGE  = 3'd2,
        ST_ABSENT = 3'd3,
        ST_HALT   = 3'd4
    } t_status;

    // return value source
    typedef enum logic [1:0] {
        RET_NEG,
        RET_OLD,
        RET_SCAN
    } t_ret_sel;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SPAWN,
        S_FIND,
        S_MOVE,
        S_FETCH,
        S_DISP
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic     latch;
        logic     emit;
        t_status  st;
        t_ret_sel ret_sel;
        logic     disp;
        logic     spawn_init;
        logic     spawn_step;
        logic     spawn_commit;
        logic     find_init;
        logic     find_step;
        logic     sched_init;
        logic     move;
        logic     exit_pop;
        logic     fetch;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic       halted;
        logic [2:0] req;
        logic       tgt_oor;
        logic       tgt_valid;
        logic       tgt_is_run;
        logic       cnt_ge2;
        logic       cnt_one;
        logic       scan_free;
        logic       scan_last;
        logic       find_hit;
    } t_stat;

endpackage
`default_nettype wire

// ----- rtl/cooperative_thread_scheduler_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// get, errors and halted answers are emitted from the decode state
// spawn checks one slot per cycle in the free-slot walk
// yield: list walk, move, fetch; schedule: move, fetch unless one thread; exit: fetch
// one request at a time: busy stays high until the result beat is registered
// o_valid pulses one cycle per result; the receiver cannot stall
// synchronous active-low reset: slot 0 is the only live, running thread
module cooperative_thread_scheduler_core #(
    parameter int SLOTS = cts_pkg::DEF_SLOTS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         i_req_type,
    input  wire logic [3:0]         i_target,
    input  wire logic [31:0]        i_entry_addr_in,
    input  wire logic signed [31:0] i_entry_arg_in,
    output logic                    o_valid,
    output logic [2:0]              o_status,
    output logic signed [3:0]       o_ret_value,
    output logic [2:0]              o_running,
    output logic                    o_switched,
    output logic                    o_fresh_start,
    output logic [31:0]             o_entry_addr_out,
    output logic signed [31:0]      o_entry_arg_out
);

    cts_pkg::t_cmd  cmd;
    cts_pkg::t_stat stat;

    // request sequencer
    cts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // slot table, ready list and result registers
    cts_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_req_type       (i_req_type),
        .i_target         (i_target),
        .i_entry_addr_in  (i_entry_addr_in),
        .i_entry_arg_in   (i_entry_arg_in),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_ret_value      (o_ret_value),
        .o_running        (o_running),
        .o_switched       (o_switched),
        .o_fresh_start    (o_fresh_start),
        .o_entry_addr_out (o_entry_addr_out),
        .o_entry_arg_out  (o_entry_arg_out)
    );

endmodule
`default_nettype wire

// ----- rtl/cts_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cts_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire cts_pkg::t_stat i_stat,
    output cts_pkg::t_cmd      o_cmd
);

    cts_pkg::t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cts_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = (r_state != cts_pkg::S_IDLE);
        case (r_state)
            cts_pkg::S_IDLE: begin
                if (start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = cts_pkg::S_DECODE;
                end
            end
            cts_pkg::S_DECODE: begin
                n_state = cts_pkg::S_IDLE;
                if (i_stat.halted) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.st      = cts_pkg::ST_HALT;
                    o_cmd.ret_sel = cts_pkg::RET_NEG;
                end else begin
                    case (i_stat.req)
                        cts_pkg::REQ_SPAWN: begin
                            o_cmd.spawn_init = 1'b1;
                            n_state          = cts_pkg::S_SPAWN;
                        end
                        cts_pkg::REQ_YIELD: begin
                            if (i_stat.tgt_oor) begin
                                o_cmd.emit    = 1'b1;
                                o_cmd.st      = cts_pkg::ST_RANGE;
                                o_cmd.ret_sel = cts_pkg::RET_NEG;
                            end else if (!i_stat.tgt_valid) begin
                                o_cmd.emit    = 1'b1;
                                o_cmd.st      = cts_pkg::ST_ABSENT;
                                o_cmd.ret_sel = cts_pkg::RET_NEG;
                            end else if (i_stat.tgt_is_run) begin
                                o_cmd.emit    = 1'b1;
                                o_cmd.st      = cts_pkg::ST_OK;
                                o_cmd.ret_sel = cts_pkg::RET_OLD;
                            end else begin
                                o_cmd.find_init = 1'b1;
                                n_state         = cts_pkg::S_FIND;
                            end
                        end
                        cts_pkg::REQ_SCHED: begin
                            if (i_stat.cnt_ge2) begin
                                o_cmd.sched_init = 1'b1;
                                n_state          = cts_pkg::S_MOVE;
                            end else begin
                                o_cmd.emit    = 1'b1;
                                o_cmd.st      = cts_pkg::ST_OK;
                                o_cmd.ret_sel = cts_pkg::RET_OLD;
                            end
                        end
                        cts_pkg::REQ_EXIT: begin
                            o_cmd.exit_pop = 1'b1;
                            if (i_stat.cnt_one) begin
                                o_cmd.emit    = 1'b1;
                                o_cmd.st      = cts_pkg::ST_HALT;
                                o_cmd.ret_sel = cts_pkg::RET_NEG;
                            end else begin
                                n_state = cts_pkg::S_FETCH;
                            end
                        end
                        default: begin
                            o_cmd.emit    = 1'b1;
                            o_cmd.st      = cts_pkg::ST_OK;
                            o_cmd.ret_sel = cts_pkg::RET_OLD;
                        end
                    endcase
                end
            end
            // walk the slots for a free one
            cts_pkg::S_SPAWN: begin
                if (i_stat.scan_free) begin
                    o_cmd.spawn_commit = 1'b1;
                    o_cmd.emit         = 1'b1;
                    o_cmd.st           = cts_pkg::ST_OK;
                    o_cmd.ret_sel      = cts_pkg::RET_SCAN;
                    n_state            = cts_pkg::S_IDLE;
                end else if (i_stat.scan_last) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.st      = cts_pkg::ST_FULL;
                    o_cmd.ret_sel = cts_pkg::RET_NEG;
                    n_state       = cts_pkg::S_IDLE;
                end else begin
                    o_cmd.spawn_step = 1'b1;
                end
            end
            // walk the list for the target
            cts_pkg::S_FIND: begin
                if (i_stat.find_hit) begin
                    n_state = cts_pkg::S_MOVE;
                end else begin
                    o_cmd.find_step = 1'b1;
                end
            end
            cts_pkg::S_MOVE: begin
                o_cmd.move = 1'b1;
                n_state    = cts_pkg::S_FETCH;
            end
            cts_pkg::S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = cts_pkg::S_DISP;
            end
            cts_pkg::S_DISP: begin
                o_cmd.emit    = 1'b1;
                o_cmd.st      = cts_pkg::ST_OK;
                o_cmd.ret_sel = cts_pkg::RET_OLD;
                o_cmd.disp    = 1'b1;
                n_state       = cts_pkg::S_IDLE;
            end
            default: begin
                n_state = cts_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/cts_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cts_datapath #(
    parameter int SLOTS = cts_pkg::DEF_SLOTS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire cts_pkg::t_cmd      i_cmd,
    output cts_pkg::t_stat          o_stat,
    input  wire logic [2:0]         i_req_type,
    input  wire logic [3:0]         i_target,
    input  wire logic [31:0]        i_entry_addr_in,
    input  wire logic signed [31:0] i_entry_arg_in,
    output logic                    o_valid,
    output logic [2:0]              o_status,
    output logic signed [3:0]       o_ret_value,
    output logic [2:0]              o_running,
    output logic                    o_switched,
    output logic                    o_fresh_start,
    output logic [31:0]             o_entry_addr_out,
    output logic signed [31:0]      o_entry_arg_out
);

    localparam int IDW = $clog2(SLOTS);
    localparam int CW  = $clog2(SLOTS + 1);
    localparam logic [IDW-1:0] LAST_ID = IDW'(SLOTS - 1);

    // control state
    logic [SLOTS-1:0] r_valid, n_valid;
    logic [SLOTS-1:0] r_started, n_started;
    logic [IDW-1:0]   r_list [SLOTS];
    logic [IDW-1:0]   n_list [SLOTS];
    logic [CW-1:0]    r_count, n_count;
    logic [IDW-1:0]   r_run;
    logic [IDW-1:0]   r_cursor;
    logic             r_halted;
    logic             r_out_valid;

    // per request working registers
    logic [2:0]       r_req;
    logic [3:0]       r_tgt;
    logic [31:0]      r_addr_in;
    logic [31:0]      r_arg_in;
    logic [IDW-1:0]   r_old;
    logic [IDW-1:0]   r_dst;
    logic [IDW-1:0]   r_scan;
    logic [IDW-1:0]   r_steps;
    logic             r_fresh;
    logic [31:0]      r_rd_addr;
    logic [31:0]      r_rd_arg;

    // slot entry store
    logic [31:0]      r_mem_addr [SLOTS];
    logic [31:0]      r_mem_arg [SLOTS];

    logic [IDW-1:0]   scan_nxt;
    logic [IDW-1:0]   cursor_nxt;
    logic [IDW-1:0]   tgt_id;
    logic [3:0]       ret_val;

    assign scan_nxt   = (r_scan == LAST_ID) ? '0 : r_scan + IDW'(1);
    assign cursor_nxt = (r_cursor == LAST_ID) ? '0 : r_cursor + IDW'(1);
    assign tgt_id     = IDW'(r_tgt);

    // status to controller
    always_comb begin
        o_stat.halted     = r_halted;
        o_stat.req        = r_req;
        o_stat.tgt_oor    = (32'(r_tgt) >= SLOTS);
        o_stat.tgt_valid  = r_valid[tgt_id];
        o_stat.tgt_is_run = (tgt_id == r_run);
        o_stat.cnt_ge2    = (r_count >= CW'(2));
        o_stat.cnt_one    = (r_count == CW'(1));
        o_stat.scan_free  = !r_valid[r_scan];
        o_stat.scan_last  = (r_steps == LAST_ID);
        o_stat.find_hit   = (r_list[r_scan] == r_dst);
    end

    // next list, count and slot bits
    always_comb begin
        n_list    = r_list;
        n_count   = r_count;
        n_valid   = r_valid;
        n_started = r_started;
        if (i_cmd.move) begin
            for (int i = 0; i < SLOTS - 1; i++) begin
                if (i >= int'(r_scan)) begin
                    n_list[i] = r_list[i+1];
                end
            end
            n_list[IDW'(r_count - CW'(1))] = r_old;
            n_list[0] = r_dst;
        end
        if (i_cmd.exit_pop) begin
            for (int i = 0; i < SLOTS - 1; i++) begin
                n_list[i] = r_list[i+1];
            end
            n_list[SLOTS-1] = '0;
            n_count         = r_count - CW'(1);
            n_valid[r_run]  = 1'b0;
        end
        if (i_cmd.spawn_commit) begin
            if (r_count < CW'(SLOTS)) begin
                n_list[IDW'(r_count)] = r_scan;
                n_count = r_count + CW'(1);
            end
            n_valid[r_scan]   = 1'b1;
            n_started[r_scan] = 1'b0;
        end
        if (i_cmd.fetch) begin
            n_started[r_dst] = 1'b1;
        end
    end

    // return value select
    always_comb begin
        case (i_cmd.ret_sel)
            cts_pkg::RET_OLD:  ret_val = 4'(r_old);
            cts_pkg::RET_SCAN: ret_val = 4'(r_scan);
            default:           ret_val = 4'hF;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= SLOTS'(1);
            r_started   <= SLOTS'(1);
            for (int i = 0; i < SLOTS; i++) begin
                r_list[i] <= '0;
            end
            r_count     <= CW'(1);
            r_run       <= '0;
            r_cursor    <= LAST_ID;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_valid     <= n_valid;
            r_started   <= n_started;
            r_list      <= n_list;
            r_count     <= n_count;
            r_out_valid <= i_cmd.emit;
            if (i_cmd.spawn_commit) begin
                r_cursor <= r_scan;
            end
            if (i_cmd.exit_pop && r_count == CW'(1)) begin
                r_halted <= 1'b1;
            end
            if (i_cmd.fetch) begin
                r_run <= r_dst;
            end
        end
    end

    // working and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req     <= i_req_type;
            r_tgt     <= i_target;
            r_addr_in <= i_entry_addr_in;
            r_arg_in  <= i_entry_arg_in;
            r_old     <= r_run;
        end
        if (i_cmd.spawn_init) begin
            r_scan  <= cursor_nxt;
            r_steps <= '0;
        end
        if (i_cmd.spawn_step) begin
            r_scan  <= scan_nxt;
            r_steps <= r_steps + IDW'(1);
        end
        if (i_cmd.find_init) begin
            r_scan <= IDW'(1);
            r_dst  <= tgt_id;
        end
        if (i_cmd.find_step) begin
            r_scan <= scan_nxt;
        end
        if (i_cmd.sched_init) begin
            r_scan <= IDW'(1);
            r_dst  <= r_list[1];
        end
        if (i_cmd.exit_pop) begin
            r_dst <= r_list[1];
        end
        if (i_cmd.fetch) begin
            r_fresh <= !r_started[r_dst];
        end
        if (i_cmd.emit) begin
            o_status         <= i_cmd.st;
            o_ret_value      <= ret_val;
            o_running        <= 3'(r_run);
            o_switched       <= i_cmd.disp;
            o_fresh_start    <= i_cmd.disp & r_fresh;
            o_entry_addr_out <= (i_cmd.disp && r_fresh) ? r_rd_addr : '0;
            o_entry_arg_out  <= (i_cmd.disp && r_fresh) ? r_rd_arg : '0;
        end
    end

    // slot entry store: write on spawn, read on fetch
    always_ff @(posedge i_clk) begin
        if (i_cmd.spawn_commit) begin
            r_mem_addr[r_scan] <= r_addr_in;
            r_mem_arg[r_scan]  <= r_arg_in;
        end
        if (i_cmd.fetch) begin
            r_rd_addr <= r_mem_addr[r_dst];
            r_rd_arg  <= r_mem_arg[r_dst];
        end
    end

    assign o_valid = r_out_valid;

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

    localparam int NSLOT     = 8;
    localparam int CYC_LIMIT = 300000;

    // one request beat
    typedef struct packed {
        logic [2:0]  req;
        logic [3:0]  tgt;
        logic [31:0] addr;
        logic [31:0] arg;
    } t_req_beat;

    // one result beat
    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  ret;
        logic [2:0]  running;
        logic        switched;
        logic        fresh;
        logic [31:0] addr;
        logic [31:0] arg;
    } t_res_beat;

    // scheduler state
    typedef struct packed {
        logic [NSLOT-1:0]            valid;
        logic [NSLOT-1:0]            started;
        logic [NSLOT-1:0][31:0]      addr;
        logic [NSLOT-1:0][31:0]      arg;
        logic [NSLOT-1:0][2:0]       lst;
        logic [3:0]                  cnt;
        logic [2:0]                  run;
        logic [2:0]                  cursor;
        logic                        halted;
    } t_sched;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_req_type = '0;
    logic [3:0]  i_target = '0;
    logic [31:0] i_entry_addr_in = '0;
    logic signed [31:0] i_entry_arg_in = '0;
    logic        o_valid;
    logic [2:0]  o_status;
    logic signed [3:0] o_ret_value;
    logic [2:0]  o_running;
    logic        o_switched;
    logic        o_fresh_start;
    logic [31:0] o_entry_addr_out;
    logic signed [31:0] o_entry_arg_out;

    cooperative_thread_scheduler_core #(.SLOTS(NSLOT)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req_type(i_req_type), .i_target(i_target),
        .i_entry_addr_in(i_entry_addr_in), .i_entry_arg_in(i_entry_arg_in),
        .o_valid(o_valid), .o_status(o_status), .o_ret_value(o_ret_value),
        .o_running(o_running), .o_switched(o_switched), .o_fresh_start(o_fresh_start),
        .o_entry_addr_out(o_entry_addr_out), .o_entry_arg_out(o_entry_arg_out)
    );

    always #10 i_clk = ~i_clk;

    t_req_beat pending_reqs[$];
    t_res_beat expected_res[$];
    t_sched    chk_state;
    t_sched    gen_state;
    t_req_beat cur_beat;
    int        idle_pct = 0;
    int        errors = 0;
    int        cycles = 0;
    int        n_results = 0;
    int        n_switches = 0;
    int        n_fresh = 0;
    int        n_halted = 0;

    function automatic t_sched sched_reset();
        t_sched s;
        s = '0;
        s.valid[0] = 1'b1;
        s.started[0] = 1'b1;
        s.cnt = 4'd1;
        s.cursor = 3'(NSLOT - 1);
        return s;
    endfunction

    // move t to the head, current runner to the tail
    function automatic void rotate_to(inout t_sched s, input logic [2:0] t);
        logic [NSLOT-1:0][2:0] tmp;
        int n;
        tmp = '0;
        tmp[0] = t;
        n = 1;
        for (int k = 1; k < NSLOT; k++) begin
            if (k < s.cnt && s.lst[k] != t && n < NSLOT - 1) begin
                tmp[n] = s.lst[k];
                n++;
            end
        end
        tmp[n] = s.run;
        n++;
        s.lst = tmp;
        s.cnt = 4'(n);
    endfunction

    function automatic void dispatch(inout t_sched s, inout t_res_beat r,
                                     input logic [2:0] id);
        s.run = id;
        r.running = id;
        r.switched = 1'b1;
        if (!s.started[id]) begin
            s.started[id] = 1'b1;
            r.fresh = 1'b1;
            r.addr = s.addr[id];
            r.arg = s.arg[id];
        end
    endfunction

    // predicted result of one request, advancing the state
    function automatic t_res_beat sched_step(inout t_sched s, input t_req_beat b);
        t_res_beat r;
        logic [2:0] id;
        logic [2:0] old;
        logic found;
        r = '0;
        r.running = s.run;
        if (s.halted) begin
            r.status = cts_pkg::ST_HALT;
            r.ret = 4'hF;
            return r;
        end
        case (b.req)
            cts_pkg::REQ_SPAWN: begin
                found = 1'b0;
                id = s.cursor;
                for (int k = 0; k < NSLOT; k++) begin
                    id = id + 3'd1;
                    if (!found && !s.valid[id]) begin
                        found = 1'b1;
                        s.cursor = id;
                        s.valid[id] = 1'b1;
                        s.started[id] = 1'b0;
                        s.addr[id] = b.addr;
                        s.arg[id] = b.arg;
                        if (s.cnt < NSLOT) begin
                            s.lst[s.cnt] = id;
                            s.cnt++;
                        end
                        r.status = cts_pkg::ST_OK;
                        r.ret = {1'b0, id};
                    end
                end
                if (!found) begin
                    r.status = cts_pkg::ST_FULL;
                    r.ret = 4'hF;
                end
            end
            cts_pkg::REQ_YIELD: begin
                if (b.tgt >= NSLOT) begin
                    r.status = cts_pkg::ST_RANGE;
                    r.ret = 4'hF;
                end else if (!s.valid[b.tgt[2:0]]) begin
                    r.status = cts_pkg::ST_ABSENT;
                    r.ret = 4'hF;
                end else if (b.tgt[2:0] == s.run) begin
                    r.ret = b.tgt;
                end else begin
                    r.ret = {1'b0, s.run};
                    rotate_to(s, b.tgt[2:0]);
                    dispatch(s, r, b.tgt[2:0]);
                end
            end
            cts_pkg::REQ_SCHED: begin
                r.ret = {1'b0, s.run};
                if (s.cnt >= 2) begin
                    id = s.lst[1];
                    rotate_to(s, id);
                    dispatch(s, r, id);
                end
            end
            cts_pkg::REQ_EXIT: begin
                old = s.run;
                s.valid[old] = 1'b0;
                if (s.cnt > 0) begin
                    for (int k = 0; k < NSLOT - 1; k++) s.lst[k] = s.lst[k+1];
                    s.lst[NSLOT-1] = '0;
                    s.cnt--;
                end
                if (s.cnt == 0) begin
                    s.halted = 1'b1;
                    r.status = cts_pkg::ST_HALT;
                    r.ret = 4'hF;
                end else begin
                    r.ret = {1'b0, old};
                    dispatch(s, r, s.lst[0]);
                end
            end
            default: r.ret = {1'b0, s.run};
        endcase
        return r;
    endfunction

    // queue one request and track it in the stimulus-side state
    task automatic add_req(input logic [2:0] req, input logic [3:0] tgt,
                           input logic [31:0] addr, input logic [31:0] arg);
        t_req_beat b;
        t_res_beat unused;
        b = '{req: req, tgt: tgt, addr: addr, arg: arg};
        unused = sched_step(gen_state, b);
        pending_reqs.push_back(b);
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || start || expected_res.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("mismatch @%0d: %s got %0h want %0h", cycles, what, got, want);
        errors++;
    endtask

    // driver: one beat per start/busy handshake
    always @(posedge i_clk) begin
        t_res_beat r;
        if (i_rst_n) begin
            if (start && !busy) begin
                r = sched_step(chk_state, cur_beat);
                expected_res.push_back(r);
            end
            if (!(start && busy)) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    cur_beat = pending_reqs.pop_front();
                    i_req_type <= cur_beat.req;
                    i_target <= cur_beat.tgt;
                    i_entry_addr_in <= cur_beat.addr;
                    i_entry_arg_in <= cur_beat.arg;
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result beat with the oldest prediction
    always @(posedge i_clk) begin
        t_res_beat e;
        if (i_rst_n && o_valid) begin
            if (expected_res.size() == 0) begin
                report("unexpected result", {29'd0, o_status}, '0);
            end else begin
                e = expected_res.pop_front();
                n_results++;
                if (o_switched) n_switches++;
                if (o_fresh_start) n_fresh++;
                if (o_status == cts_pkg::ST_HALT) n_halted++;
                if (o_status !== e.status)
                    report("status", 32'(o_status), 32'(e.status));
                if (o_ret_value !== e.ret)
                    report("ret_value", 32'(o_ret_value[3:0]), 32'(e.ret));
                if (o_running !== e.running)
                    report("running", 32'(o_running), 32'(e.running));
                if (o_switched !== e.switched)
                    report("switched", 32'(o_switched), 32'(e.switched));
                if (o_fresh_start !== e.fresh)
                    report("fresh_start", 32'(o_fresh_start), 32'(e.fresh));
                if (o_entry_addr_out !== e.addr)
                    report("entry_addr_out", o_entry_addr_out, e.addr);
                if (o_entry_arg_out !== e.arg)
                    report("entry_arg_out", o_entry_arg_out, e.arg);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("cooperative_thread_scheduler_core regression: fail");
            $finish;
        end
    end

    initial begin
        int pick;
        logic [2:0] gone;
        chk_state = sched_reset();
        gen_state = sched_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: fill the table, then error cases and every request kind
        add_req(cts_pkg::REQ_GET, 4'd0, '0, '0);
        add_req(cts_pkg::REQ_SPAWN, 4'd0, 32'h0, 32'h8000_0000);
        add_req(cts_pkg::REQ_SPAWN, 4'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        add_req(cts_pkg::REQ_SPAWN, 4'd0, 32'hAAAA_5555, 32'hFFFF_FFFF);
        add_req(cts_pkg::REQ_SPAWN, 4'd0, 32'h5555_AAAA, 32'h0);
        add_req(cts_pkg::REQ_SPAWN, 4'd0, $urandom, $urandom);
        add_req(cts_pkg::REQ_SPAWN, 4'd0, $urandom, $urandom);
        add_req(cts_pkg::REQ_SPAWN, 4'd0, $urandom, $urandom);
        add_req(cts_pkg::REQ_SPAWN, 4'd0, $urandom, $urandom);
        add_req(cts_pkg::REQ_YIELD, 4'd15, '0, '0);
        add_req(cts_pkg::REQ_YIELD, 4'd8, '0, '0);
        add_req(cts_pkg::REQ_YIELD, 4'd0, '0, '0);
        add_req(cts_pkg::REQ_YIELD, 4'd3, '0, '0);
        add_req(cts_pkg::REQ_SCHED, 4'd0, '0, '0);
        gone = gen_state.run;
        add_req(cts_pkg::REQ_EXIT, 4'd0, '0, '0);
        add_req(cts_pkg::REQ_YIELD, {1'b0, gone}, '0, '0);
        add_req(3'd5, 4'd0, '0, '0);
        add_req(3'd7, 4'd0, '0, '0);
        add_req(cts_pkg::REQ_SCHED, 4'd0, '0, '0);
        drain();

        // random phases with varied sender gaps
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1) ? 76 : (ph == 3) ? 30 : 0;
            for (int n = 0; n < 150; n++) begin
                pick = $urandom_range(99);
                if (pick < 28) begin
                    add_req(cts_pkg::REQ_SPAWN, 4'($urandom), $urandom, $urandom);
                end else if (pick < 55) begin
                    if ($urandom_range(4) != 0)
                        add_req(cts_pkg::REQ_YIELD,
                                {1'b0, gen_state.lst[$urandom_range(gen_state.cnt - 1)]},
                                $urandom, $urandom);
                    else
                        add_req(cts_pkg::REQ_YIELD, 4'($urandom_range(15)),
                                $urandom, $urandom);
                end else if (pick < 72) begin
                    add_req(cts_pkg::REQ_SCHED, 4'($urandom), $urandom, $urandom);
                end else if (pick < 90) begin
                    // keep at least one thread alive until the final phase
                    if (gen_state.cnt > 1)
                        add_req(cts_pkg::REQ_EXIT, 4'($urandom), $urandom, $urandom);
                    else
                        add_req(cts_pkg::REQ_SPAWN, 4'($urandom), $urandom, $urandom);
                end else begin
                    add_req(3'($urandom_range(4, 7)), 4'($urandom), $urandom, $urandom);
                end
            end
            // hold off until every result is back
            drain();
        end

        // last thread exits, then requests while halted
        idle_pct = 0;
        while (!gen_state.halted) add_req(cts_pkg::REQ_EXIT, '0, '0, '0);
        add_req(cts_pkg::REQ_GET, '0, '0, '0);
        add_req(cts_pkg::REQ_SPAWN, '0, $urandom, $urandom);
        add_req(cts_pkg::REQ_YIELD, 4'd0, '0, '0);
        add_req(cts_pkg::REQ_SCHED, '0, '0, '0);
        drain();
        repeat (2 * NSLOT + 8) @(posedge i_clk);

        $display("covered %0d results: %0d thread switches, %0d fresh dispatches, %0d halted",
                 n_results, n_switches, n_fresh, n_halted);
        $display("spawn, yield, schedule, exit, get and unused codes under varied gaps");
        if (errors == 0) begin
            $display("cooperative_thread_scheduler_core regression: pass");
        end else begin
            $display("cooperative_thread_scheduler_core regression: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ----- cooperative_thread_scheduler_core.f -----
rtl/cts_pkg.sv
rtl/cts_ctrl.sv
rtl/cts_datapath.sv
rtl/cooperative_thread_scheduler_core.sv
bench/tb_top.sv
